[rtl/core/fwq_pkg.sv]
// Shared types and constants for the FIFO wait queue with remove by key.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package fwq_pkg;

	// Queue geometry and field widths.
	localparam int QUEUE_DEPTH = 16;
	localparam int PID_BITS    = 15;
	localparam int HANDLE_BITS = 16;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// Operation codes.
	localparam logic [1:0] OP_ENQUEUE = 2'd0;
	localparam logic [1:0] OP_DEQUEUE = 2'd1;
	localparam logic [1:0] OP_REMOVE  = 2'd2;

	// Status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_NULL  = 2'd3;

	// Request carried by one input transaction.
	typedef struct packed {
		logic [1:0]             opcode;
		logic [PID_BITS-1:0]    key_pid;
		logic [HANDLE_BITS-1:0] entry_handle;
	} req_t;

	// Result carried by one output transaction.
	typedef struct packed {
		logic [1:0]             status;
		logic [HANDLE_BITS-1:0] out_handle;
		logic [PID_BITS-1:0]    out_pid;
		logic [CNT_W-1:0]       entry_count;
		logic                   queue_empty;
	} rsp_t;

	// Per-cell control from the queue controller.
	typedef struct packed {
		logic shift;
		logic load;
		logic capture;
	} cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/core/fifo_wait_queue_remove_by_key.sv]
// Top level of the FIFO wait queue with remove by key: a chain of entry cells
// and the controller that steers it. Depends on fwq_pkg and fwq_cell.
//
// Enqueue, dequeue and the unused opcode give the result strobe done in the
// cycle after start is accepted, and a new transaction may be accepted in
// every cycle while busy is low. For a remove, every cell compares its entry
// with the key in the accept cycle, busy is then high for one cycle while the
// first matching live cell is selected and the cells behind it shift one
// place toward the head, and done follows in the next cycle.
// Each result is shown for exactly one cycle and must be taken then; the
// receiver cannot stall the block. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module fifo_wait_queue_remove_by_key (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire fwq_pkg::req_t req,
	output logic               busy,
	output logic               done,
	output fwq_pkg::rsp_t      rsp
);
	import fwq_pkg::*;

	localparam int D = QUEUE_DEPTH;

	logic             busy_q;
	logic             done_q;
	rsp_t             rsp_q;
	logic [CNT_W-1:0] count_q;

	logic                   accept;
	logic                   enq_ok;
	logic                   deq_ok;
	logic                   capture;
	logic                   any_hit;
	logic [D-1:0]           live;
	logic [D-1:0]           hit;
	logic [D-1:0]           first;
	logic [D-1:0]           rm_shift;
	logic [PID_BITS-1:0]    sel_pid;
	logic [HANDLE_BITS-1:0] sel_handle;
	rsp_t                   rsp_d;
	logic [CNT_W-1:0]       count_d;

	cell_ctrl_t             ctrl    [D];
	logic [PID_BITS-1:0]    c_pid   [D];
	logic [HANDLE_BITS-1:0] c_handle[D];
	logic [D-1:0]           c_match;

	assign accept  = start && !busy_q;
	assign enq_ok  = accept && (req.opcode == OP_ENQUEUE) && (req.entry_handle != '0)
		&& (count_q < CNT_W'(D));
	assign deq_ok  = accept && (req.opcode == OP_DEQUEUE) && (count_q != '0);
	assign capture = accept && (req.opcode == OP_REMOVE);

	// Cell chain: each cell takes its neighbor's entry toward the head.
	for (genvar i = 0; i < D; i++) begin : g_cell
		localparam logic [D-1:0] LOWER = (D'(1) << i) - D'(1);

		logic [PID_BITS-1:0]    nxt_pid;
		logic [HANDLE_BITS-1:0] nxt_handle;

		if (i == D - 1) begin : g_last
			assign nxt_pid    = '0;
			assign nxt_handle = '0;
		end else begin : g_mid
			assign nxt_pid    = c_pid[i+1];
			assign nxt_handle = c_handle[i+1];
		end

		// A cell is live below the count; cells at and behind the first hit shift.
		assign live[i]     = CNT_W'(i) < count_q;
		assign hit[i]      = c_match[i] && live[i];
		assign first[i]    = hit[i] && ((hit & LOWER) == '0);
		assign rm_shift[i] = hit[i] || ((hit & LOWER) != '0);

		assign ctrl[i].load    = enq_ok && (count_q == CNT_W'(i));
		assign ctrl[i].shift   = deq_ok || (busy_q && rm_shift[i]);
		assign ctrl[i].capture = capture;

		fwq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl[i]),
			.key_pid   (req.key_pid),
			.new_handle(req.entry_handle),
			.nxt_pid   (nxt_pid),
			.nxt_handle(nxt_handle),
			.pid       (c_pid[i]),
			.handle    (c_handle[i]),
			.match     (c_match[i])
		);
	end

	// Select the entry of the first matching cell.
	always_comb begin
		sel_pid    = '0;
		sel_handle = '0;
		for (int i = 0; i < D; i++) begin
			sel_pid    = sel_pid | (c_pid[i] & {PID_BITS{first[i]}});
			sel_handle = sel_handle | (c_handle[i] & {HANDLE_BITS{first[i]}});
		end
	end

	assign any_hit = hit != '0;

	// Next result and count.
	always_comb begin
		rsp_d   = '0;
		count_d = count_q;
		if (busy_q) begin
			if (any_hit) begin
				rsp_d.status     = ST_OK;
				rsp_d.out_pid    = sel_pid;
				rsp_d.out_handle = sel_handle;
				count_d          = count_q - CNT_W'(1);
			end else begin
				rsp_d.status = ST_EMPTY;
			end
		end else begin
			case (req.opcode)
				OP_ENQUEUE: begin
					if (req.entry_handle == '0) begin
						rsp_d.status = ST_NULL;
					end else if (count_q >= CNT_W'(D)) begin
						rsp_d.status = ST_FULL;
					end else begin
						rsp_d.status = ST_OK;
						count_d      = count_q + CNT_W'(1);
					end
				end
				OP_DEQUEUE: begin
					if (count_q != '0) begin
						rsp_d.status     = ST_OK;
						rsp_d.out_pid    = c_pid[0];
						rsp_d.out_handle = c_handle[0];
						count_d          = count_q - CNT_W'(1);
					end else begin
						rsp_d.status = ST_EMPTY;
					end
				end
				default: begin
					rsp_d.status = ST_EMPTY;
				end
			endcase
		end
		rsp_d.entry_count = count_d;
		rsp_d.queue_empty = (count_d == '0);
	end

	// Control state: count, remove phase and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			busy_q <= capture;
			done_q <= busy_q || (accept && !capture);
			if (busy_q || (accept && !capture)) begin
				count_q <= count_d;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (busy_q || (accept && !capture)) begin
			rsp_q <= rsp_d;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

`default_nettype wire

[rtl/core/fwq_cell.sv]
// One storage cell of the wait queue chain: holds one entry and its match flag.
// Depends on fwq_pkg for widths and the cell control struct.
`timescale 1ns / 1ps
`default_nettype none

module fwq_cell (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire fwq_pkg::cell_ctrl_t             ctrl,
	input  wire logic [fwq_pkg::PID_BITS-1:0]    key_pid,
	input  wire logic [fwq_pkg::HANDLE_BITS-1:0] new_handle,
	input  wire logic [fwq_pkg::PID_BITS-1:0]    nxt_pid,
	input  wire logic [fwq_pkg::HANDLE_BITS-1:0] nxt_handle,
	output logic      [fwq_pkg::PID_BITS-1:0]    pid,
	output logic      [fwq_pkg::HANDLE_BITS-1:0] handle,
	output logic                                 match
);
	import fwq_pkg::*;

	logic [PID_BITS-1:0]    pid_q;
	logic [HANDLE_BITS-1:0] handle_q;
	logic                   match_q;

	// Entry storage: load a new entry at the tail, or take the neighbor's entry.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			pid_q    <= key_pid;
			handle_q <= new_handle;
		end else if (ctrl.shift) begin
			pid_q    <= nxt_pid;
			handle_q <= nxt_handle;
		end
	end

	// The key compare is captured when a remove transaction is accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctrl.capture) begin
			match_q <= (pid_q == key_pid);
		end
	end

	assign pid    = pid_q;
	assign handle = handle_q;
	assign match  = match_q;

endmodule

`default_nettype wire

[rtl/core/fwq_checker.sv]
// Port-level checks for the FIFO wait queue, bound to the top level.
// Depends on fwq_pkg and fifo_wait_queue_remove_by_key.
`timescale 1ns / 1ps
`default_nettype none

module fwq_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          start,
	input wire logic          busy,
	input wire logic          done,
	input wire fwq_pkg::rsp_t rsp
);
	import fwq_pkg::*;

	// The remove phase lasts exactly one cycle and ends in a result.
	a_busy_one: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy && done)
		else $error("busy lasted more than one cycle or gave no result");

	// Every accepted transaction gives a result in the next cycle unless it is a remove.
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("accepted transaction produced neither result nor remove phase");

	// The empty flag agrees with the count, and the count stays within depth.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((rsp.queue_empty == (rsp.entry_count == '0))
			&& (rsp.entry_count <= CNT_W'(QUEUE_DEPTH))))
		else $error("count or empty flag inconsistent");

	// No entry is returned unless the status is ok.
	a_no_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.status != ST_OK)) |-> ((rsp.out_pid == '0) && (rsp.out_handle == '0)))
		else $error("entry returned with failing status");

endmodule

bind fifo_wait_queue_remove_by_key fwq_checker u_fwq_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.rsp   (rsp)
);

`default_nettype wire

[test/wait_queue_monitor.sv]
// Result checker for the FIFO wait queue with remove by key: it predicts
// each result from the accepted requests and compares it with the result
// that the block returns. Depends on fwq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wait_queue_monitor (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic          busy,
	input  wire logic          done,
	input  wire fwq_pkg::req_t req,
	input  wire fwq_pkg::rsp_t rsp,
	output int                 mismatches,
	output int                 outstanding
);
	import fwq_pkg::*;

	// Predicted queue contents, slot 0 at the head.
	logic [PID_BITS-1:0]    model_pid    [QUEUE_DEPTH];
	logic [HANDLE_BITS-1:0] model_handle [QUEUE_DEPTH];
	int                     model_count;

	// Results that have been predicted but not yet returned, oldest first.
	rsp_t pending_results [$];

	// Apply one request to the predicted queue and return its result.
	function automatic rsp_t serve_request(input req_t r);
		rsp_t res;
		int   hit;
		res = '0;
		res.status = ST_EMPTY;
		hit = -1;
		case (r.opcode)
			OP_ENQUEUE: begin
				if (r.entry_handle == '0) begin
					res.status = ST_NULL;
				end else if (model_count >= QUEUE_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					model_pid[model_count] = r.key_pid;
					model_handle[model_count] = r.entry_handle;
					model_count++;
					res.status = ST_OK;
				end
			end
			OP_DEQUEUE: begin
				if (model_count > 0)
					hit = 0;
			end
			OP_REMOVE: begin
				// Scan from the tail so that the match nearest the head wins.
				for (int i = model_count - 1; i >= 0; i--)
					if (model_pid[i] == r.key_pid)
						hit = i;
			end
			default: begin
			end
		endcase

		// Take out the selected entry and close the gap behind it.
		if (hit >= 0) begin
			res.status = ST_OK;
			res.out_handle = model_handle[hit];
			res.out_pid = model_pid[hit];
			for (int i = hit; i < model_count - 1; i++) begin
				model_pid[i] = model_pid[i + 1];
				model_handle[i] = model_handle[i + 1];
			end
			model_count--;
		end
		res.entry_count = CNT_W'(model_count);
		res.queue_empty = (model_count == 0);
		return res;
	endfunction

	// Count a failure; only the first few are reported in detail.
	task automatic note_failure(input string what, input rsp_t want, input rsp_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected status=%0d handle=%h pid=%h count=%0d empty=%b, got status=%0d handle=%h pid=%h count=%0d empty=%b",
				$realtime, what, want.status, want.out_handle, want.out_pid,
				want.entry_count, want.queue_empty, got.status, got.out_handle,
				got.out_pid, got.entry_count, got.queue_empty);
	endtask

	// Compare returned results first, then record the request accepted at this edge.
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			model_count = 0;
			pending_results.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (done) begin
				if (pending_results.size() == 0) begin
					note_failure("result with no request waiting", '0, rsp);
				end else begin
					want = pending_results.pop_front();
					if (want !== rsp)
						note_failure("result mismatch", want, rsp);
				end
			end
			if (start && !busy)
				pending_results.push_back(serve_request(req));
			outstanding = pending_results.size();
		end
	end

endmodule

`default_nettype wire

[test/tb_fifo_wait_queue_remove_by_key.sv]
// Testbench top for the FIFO wait queue with remove by key: it drives directed
// and random requests and gives the verdict. Depends on fwq_pkg, the block
// and wait_queue_monitor.
`timescale 1ns / 1ps
`default_nettype none

module tb_fifo_wait_queue_remove_by_key;
	import fwq_pkg::*;

	// The opcode that the block treats as no operation.
	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         PHASE_ITEMS = 475;
	localparam int         STALL_LIMIT = 4000;

	logic clk;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic done;
	rsp_t rsp;
	int   mismatches;
	int   outstanding;
	int   idle_pct;
	int   stall_cycles;

	fifo_wait_queue_remove_by_key dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	wait_queue_monitor result_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.done        (done),
		.req         (req),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog: ends the run when no transaction moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic req_t request(input logic [1:0] op, input logic [PID_BITS-1:0] pid,
		input logic [HANDLE_BITS-1:0] handle);
		req_t r;
		r.opcode = op;
		r.key_pid = pid;
		r.entry_handle = handle;
		return r;
	endfunction

	// Offer one request, with random idle cycles ahead of it, and hold it until
	// the block takes it. Returns at the next falling edge.
	task automatic issue(input req_t r);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// Hold off new requests until every predicted result has come back.
	task automatic drain();
		start <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	// Stimulus.
	initial begin
		int                     roll;
		int                     enq_pct;
		logic [1:0]             op;
		logic [PID_BITS-1:0]    pid;
		logic [HANDLE_BITS-1:0] handle;

		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		idle_pct = 19;
		enq_pct = 50;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: operations on an empty queue.
		issue(request(OP_ENQUEUE, 15'h7fff, 16'h0000));
		issue(request(OP_DEQUEUE, 15'h0000, 16'h0000));
		issue(request(OP_REMOVE, 15'h7fff, 16'hffff));
		issue(request(OP_UNUSED, 15'h7fff, 16'hffff));

		// Directed: fill the queue, with repeated ids and the field extremes.
		for (int i = 0; i < QUEUE_DEPTH; i++)
			issue(request(OP_ENQUEUE,
				(i == 0) ? 15'h0000 : (i == QUEUE_DEPTH - 1) ? 15'h7fff : PID_BITS'(i % 5),
				(i == 0) ? 16'hffff : (i == 1) ? 16'h0001 : HANDLE_BITS'(i * 4099 + 1)));

		// Directed: full queue, null entry on a full queue, removal of a repeated
		// id, of the tail, of a missing id, then a dequeue and a no-op.
		issue(request(OP_ENQUEUE, 15'h0005, 16'h1234));
		issue(request(OP_ENQUEUE, 15'h0005, 16'h0000));
		issue(request(OP_REMOVE, 15'h0003, 16'h0000));
		issue(request(OP_REMOVE, 15'h7fff, 16'h0000));
		issue(request(OP_REMOVE, 15'h2aaa, 16'h5555));
		issue(request(OP_DEQUEUE, 15'h0000, 16'h0000));
		issue(request(OP_UNUSED, 15'h0000, 16'h0000));

		// Random phases: moderate sender gaps, heavy gaps, then back to back.
		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 19 : (phase == 1) ? 65 : 0;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// Swing between filling and draining so that depth varies widely.
				if (k % 40 == 0)
					enq_pct = $urandom_range(75, 25);
				if (k == PHASE_ITEMS / 2)
					drain();
				roll = $urandom_range(99);
				if (roll < enq_pct)
					op = OP_ENQUEUE;
				else if (roll >= 96)
					op = OP_UNUSED;
				else if (roll[0])
					op = OP_DEQUEUE;
				else
					op = OP_REMOVE;
				// A small id pool makes removals hit and repeats common.
				if ($urandom_range(9) < 8)
					pid = PID_BITS'($urandom_range(7));
				else
					pid = PID_BITS'($urandom);
				if ($urandom_range(29) == 0)
					handle = '0;
				else
					handle = HANDLE_BITS'($urandom);
				issue(request(op, pid, handle));
			end
		end

		// Let the last results arrive, then give the verdict.
		drain();
		repeat (4) @(negedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire

[filelist.f]
rtl/core/fwq_pkg.sv
rtl/core/fwq_cell.sv
rtl/core/fifo_wait_queue_remove_by_key.sv
rtl/core/fwq_checker.sv
test/wait_queue_monitor.sv
test/tb_fifo_wait_queue_remove_by_key.sv
